@@ design/pcaa_pkg.sv @@
// Shared constants, payload types and helpers for the pose cell activity array.
package pcaa_pkg;

   localparam int SIDE      = 16;
   localparam int LAYERS    = 16;
   localparam int NUM_CELLS = SIDE * SIDE * LAYERS;
   localparam int CELL_AW   = $clog2(NUM_CELLS);
   localparam int DIV_STEPS = 48;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   localparam logic [2:0] OP_WRITE     = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_INHIBIT   = 3'd2;
   localparam logic [2:0] OP_NORMALIZE = 3'd3;
   localparam logic [2:0] OP_READ      = 3'd4;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_RANGE    = 2'd1;
   localparam logic [1:0] STS_TOTAL    = 2'd2;

   localparam logic signed [47:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]         operation;
      logic [5:0]         x_pos;
      logic [5:0]         y_pos;
      logic [5:0]         layer;
      logic signed [31:0] value;
      logic               starts_pass;
   } req_type;

   typedef struct packed {
      logic signed [31:0] cell_value;
      logic signed [47:0] total_out;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic div_step;
      logic finish;
      logic clear_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic need_div;
      logic div_done;
   } ctrl_sts_type;

   function automatic logic signed [31:0] clamp33(logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ design/pcaa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pcaa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/pcaa_datapath.sv @@
// Datapath: request latch, cell arithmetic, running total, divider and cell store.
module pcaa_datapath import pcaa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  logic         csr_we,
   input  logic [30:0]  csr_wdata,
   input  ctrl_cmd_type cmd,
   output ctrl_sts_type sts,
   output rsp_type      rsp_data
);

   req_type                req_ff;
   logic [CELL_AW-1:0]     idx_ff, idx_in;
   logic                   in_range_ff, in_range_in;
   logic [30:0]            level_ff;
   logic signed [47:0]     total_ff, total_in;
   logic signed [31:0]     cell_ff, cell_in;
   logic [1:0]             status_ff, status_in;
   logic                   div_ff, div_in;
   logic                   neg_ff;
   logic [47:0]            rem_ff, rem_in;
   logic [47:0]            quo_ff, quo_in;
   logic [47:0]            dvd_ff, dvd_in;
   logic [DIV_CW-1:0]      cnt_ff;
   logic [CELL_AW-1:0]     clr_ff;
   rsp_type                rsp_ff;

   logic signed [31:0]     rd_cell;
   logic [31:0]            rd_raw;
   logic signed [31:0]     add_res, diff_sat, inh_res;
   logic signed [47:0]     base_total;
   logic [48:0]            sum_total;
   logic [31:0]            mag;
   logic [48:0]            rem_shift;
   logic                   qbit;
   logic signed [31:0]     div_res, final_cell;
   logic                   total_pos;
   logic                   ram_we;
   logic [CELL_AW-1:0]     ram_waddr;
   logic [31:0]            ram_wdata;

   // coordinate check and flat index
   always_comb begin
      in_range_in = ({1'b0, req_data.x_pos} < 7'(SIDE)) &&
                    ({1'b0, req_data.y_pos} < 7'(SIDE)) &&
                    ({1'b0, req_data.layer} < 7'(LAYERS));
      idx_in = CELL_AW'(32'(req_data.x_pos) + 32'(SIDE) * 32'(req_data.y_pos) +
                        32'(SIDE * SIDE) * 32'(req_data.layer));
   end

   assign rd_cell   = $signed(rd_raw);
   assign total_pos = !total_ff[47] && (total_ff != 48'sd0);

   always_comb begin
      add_res    = clamp33(33'(rd_cell) + 33'(req_ff.value));
      diff_sat   = clamp33(33'(rd_cell) - 33'(req_ff.value));
      inh_res    = (diff_sat > $signed({1'b0, level_ff})) ?
                   (diff_sat - $signed({1'b0, level_ff})) : 32'sd0;
      base_total = req_ff.starts_pass ? 48'sd0 : total_ff;
      sum_total  = {1'b0, base_total} + {17'd0, inh_res};
      mag        = rd_cell[31] ? (32'd0 - rd_raw) : rd_raw;
   end

   always_comb begin
      cell_in   = cell_ff;
      status_in = status_ff;
      total_in  = total_ff;
      div_in    = div_ff;
      if (cmd.calc) begin
         div_in    = 1'b0;
         status_in = STS_OK;
         cell_in   = rd_cell;
         if (!in_range_ff) begin
            status_in = STS_RANGE;
            cell_in   = 32'sd0;
         end else begin
            case (req_ff.operation)
               OP_WRITE: cell_in = req_ff.value;
               OP_ADD:   cell_in = add_res;
               OP_INHIBIT: begin
                  cell_in  = inh_res;
                  total_in = (sum_total > {1'b0, TOTAL_MAX}) ? TOTAL_MAX :
                             $signed(sum_total[47:0]);
               end
               OP_NORMALIZE: begin
                  if (total_pos) begin
                     div_in = 1'b1;
                  end else begin
                     status_in = STS_TOTAL;
                  end
               end
               default: cell_in = rd_cell;
            endcase
         end
      end
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[47]};
      qbit      = rem_shift >= {2'b00, total_ff[46:0]};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvd_in    = dvd_ff;
      if (cmd.calc) begin
         rem_in = 48'd0;
         quo_in = 48'd0;
         dvd_in = {mag, 16'd0};
      end else if (cmd.div_step) begin
         rem_in = qbit ? 48'(rem_shift - {2'b00, total_ff[46:0]}) : rem_shift[47:0];
         quo_in = {quo_ff[46:0], qbit};
         dvd_in = {dvd_ff[46:0], 1'b0};
      end
   end

   always_comb begin
      if (neg_ff) begin
         div_res = (quo_ff > 48'h0000_8000_0000) ? 32'sh8000_0000 :
                   $signed(32'd0 - quo_ff[31:0]);
      end else begin
         div_res = (quo_ff > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   $signed(quo_ff[31:0]);
      end
      final_cell = div_ff ? div_res : cell_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 31'd0;
         total_ff <= 48'sd0;
         clr_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         if (csr_we) begin
            level_ff <= csr_wdata;
         end
         total_ff <= total_in;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.calc) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         idx_ff      <= idx_in;
         in_range_ff <= in_range_in;
      end
      if (cmd.calc) begin
         neg_ff <= rd_cell[31];
      end
      cell_ff   <= cell_in;
      status_ff <= status_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvd_ff    <= dvd_in;
      if (cmd.finish) begin
         rsp_ff.cell_value <= final_cell;
         rsp_ff.total_out  <= total_ff;
         rsp_ff.status     <= status_ff;
      end
   end

   assign ram_we    = cmd.clear_step || (cmd.finish && in_range_ff);
   assign ram_waddr = cmd.clear_step ? clr_ff : idx_ff;
   assign ram_wdata = cmd.clear_step ? 32'd0 : final_cell;

   pcaa_ram #(
      .WIDTH(32),
      .DEPTH(NUM_CELLS)
   ) u_cells (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(idx_ff),
      .rd_data(rd_raw)
   );

   assign sts.clear_done = clr_ff == CELL_AW'(NUM_CELLS - 1);
   assign sts.need_div   = div_in;
   assign sts.div_done   = cnt_ff == DIV_CW'(DIV_STEPS - 1);
   assign rsp_data       = rsp_ff;

   a_total_nonneg: assert property (@(posedge clock) disable iff (reset)
      !total_ff[47])
      else $error("running total went negative");
   a_clear_no_item: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !cmd.finish && !cmd.calc)
      else $error("clearing pass overlaps an item");
   a_div_keeps_total: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> $stable(total_ff))
      else $error("total changed during division");

endmodule

@@ design/pcaa_ctrl.sv @@
// Controller: sequences the clearing pass and each item through the datapath.
module pcaa_ctrl import pcaa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_LOOK  = 6'b000100,
      S_CALC  = 6'b001000,
      S_DIV   = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: state_in = S_CALC;
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = sts.need_div ? S_DIV : S_FIN;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before transfer");
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("input taken during clearing pass");
   a_calc_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC && !sts.need_div) |=> state_ff == S_FIN)
      else $error("calc did not advance to finish");

endmodule

@@ design/pose_cell_activity_array.sv @@
// Top level of the pose cell activity array: controller plus datapath.
// A SIDE x SIDE x LAYERS array of Q16.16 cells (default 16x16x16) and a Q32.16
// running total. After reset the block runs a clearing pass over all NUM_CELLS
// cells (4096 by default) of the cell memory, one cell per cycle, and holds
// req_stall high meanwhile; csr writes are taken throughout. One item is
// worked at a time: write, add, inhibit, read and out-of-range items go
// through accept, memory read, compute and write back, with the result
// registered at write back; a normalize item with a positive total runs the
// restoring divider between compute and write back, one quotient bit per
// cycle. The result register decouples the two sides: a new item is accepted
// while the previous result still waits for its transfer out. The user must
// write inhibit_level with csr_we/csr_wdata only while no item is in flight;
// the block itself does not enforce this.
module pose_cell_activity_array import pcaa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [30:0] csr_wdata
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // sequence the clearing pass and each transfer
   pcaa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // hold cells, total, divider and result register
   pcaa_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
